>>> rtl/core/fdfr_pkg.sv
// Shared types and constants for the flag-delimited frame receiver.
// Used by the front, queue, back and top-level modules; no dependencies.
package fdfr_pkg;

	localparam logic [7:0] FLAG_BYTE     = 8'h7E;
	localparam logic [7:0] ESC_BYTE      = 8'h7D;
	localparam logic [7:0] ESC_CODE_ESC  = 8'h01;
	localparam logic [7:0] ESC_CODE_FLAG = 8'h02;

	localparam int RAW_FRAME_MAX = 512;
	localparam int RAW_W         = 10;
	localparam int POS_W         = 10;
	localparam int HDR_BYTES     = 16;
	localparam int SLOT_W        = 4;
	localparam int MIN_LEN_W     = 9;
	localparam logic [MIN_LEN_W-1:0] MIN_LEN_RESET = 9'd15;

	localparam int BODY_LEN_W = 9;
	localparam int MULTI_BIT  = 13;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		STAT_GOOD     = 2'd0,
		STAT_CHECK    = 2'd1,
		STAT_SHORT    = 2'd2,
		STAT_OVERLONG = 2'd3
	} fr_status_t;

	typedef enum logic {
		ST_HUNT  = 1'b0,
		ST_FRAME = 1'b1
	} fr_state_t;

	typedef enum logic {
		TOK_PLAIN = 1'b0,
		TOK_CLOSE = 1'b1
	} tok_kind_t;

	// One unit of work from the front to the back.
	typedef struct packed {
		tok_kind_t         kind;
		logic [7:0]        data;
		logic [SLOT_W-1:0] slot;
		fr_status_t        status;
	} tok_t;

endpackage

>>> rtl/core/fdfr_front.sv
// Front part of the receiver: byte acceptance, flag hunting, unescaping,
// running check and frame status. Depends on fdfr_pkg.
module fdfr_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            min_frame_len_we,
	input  logic [fdfr_pkg::MIN_LEN_W-1:0]  min_frame_len_wdata,
	input  logic                            rx_valid,
	input  logic [7:0]                      rx_byte,
	output logic                            rx_stall,
	input  logic                            queue_full,
	output logic                            tok_push,
	output fdfr_pkg::tok_t                  tok
);

	fdfr_pkg::fr_state_t state_q, state_n;
	logic                           esc_q, esc_n;
	logic [fdfr_pkg::RAW_W-1:0]     raw_q, raw_n;
	logic [fdfr_pkg::POS_W-1:0]     pos_q, pos_n;
	logic [7:0]                     xor_q, xor_n;
	logic [fdfr_pkg::MIN_LEN_W-1:0] min_len_q;

	logic                       acc;
	logic                       is_flag;
	logic                       overlong;
	logic [7:0]                 plain_val;
	logic                       plain_take;
	logic [fdfr_pkg::POS_W-1:0] pos_inc;
	fdfr_pkg::fr_status_t       close_status;

	assign rx_stall = queue_full;
	assign acc      = rx_valid && !queue_full;
	assign is_flag  = (rx_byte == fdfr_pkg::FLAG_BYTE);
	assign overlong = (raw_q >= fdfr_pkg::RAW_W'(fdfr_pkg::RAW_FRAME_MAX - 1));
	assign pos_inc  = pos_q + fdfr_pkg::POS_W'(1);

	always_comb begin
		if (raw_q < {1'b0, min_len_q}) begin
			close_status = fdfr_pkg::STAT_SHORT;
		end else if (pos_q == '0 || xor_q != 8'h00) begin
			close_status = fdfr_pkg::STAT_CHECK;
		end else begin
			close_status = fdfr_pkg::STAT_GOOD;
		end
	end

	// An escape code other than the two known ones passes through unchanged.
	always_comb begin
		if (esc_q && rx_byte == fdfr_pkg::ESC_CODE_ESC) begin
			plain_val = fdfr_pkg::ESC_BYTE;
		end else if (esc_q && rx_byte == fdfr_pkg::ESC_CODE_FLAG) begin
			plain_val = fdfr_pkg::FLAG_BYTE;
		end else begin
			plain_val = rx_byte;
		end
	end

	// Next state.
	always_comb begin
		state_n = state_q;
		if (acc) begin
			unique case (state_q)
				fdfr_pkg::ST_HUNT: begin
					if (is_flag) begin
						state_n = fdfr_pkg::ST_FRAME;
					end
				end
				fdfr_pkg::ST_FRAME: begin
					if (is_flag) begin
						if (close_status == fdfr_pkg::STAT_GOOD) begin
							state_n = fdfr_pkg::ST_HUNT;
						end
					end else if (overlong) begin
						state_n = fdfr_pkg::ST_HUNT;
					end
				end
				default: state_n = fdfr_pkg::ST_HUNT;
			endcase
		end
	end

	// Datapath updates and token generation.
	always_comb begin
		esc_n       = esc_q;
		raw_n       = raw_q;
		pos_n       = pos_q;
		xor_n       = xor_q;
		plain_take  = 1'b0;
		tok_push    = 1'b0;
		tok.kind    = fdfr_pkg::TOK_PLAIN;
		tok.data    = plain_val;
		tok.slot    = fdfr_pkg::SLOT_W'(pos_inc - fdfr_pkg::POS_W'(1));
		tok.status  = close_status;
		if (acc) begin
			unique case (state_q)
				fdfr_pkg::ST_HUNT: begin
					if (is_flag) begin
						esc_n = 1'b0;
						raw_n = fdfr_pkg::RAW_W'(1);
						pos_n = '0;
						xor_n = 8'h00;
					end
				end
				fdfr_pkg::ST_FRAME: begin
					if (is_flag) begin
						tok_push = 1'b1;
						tok.kind = fdfr_pkg::TOK_CLOSE;
						// A rejected closing flag opens the next frame.
						esc_n    = 1'b0;
						raw_n    = fdfr_pkg::RAW_W'(1);
						pos_n    = '0;
						xor_n    = 8'h00;
					end else if (overlong) begin
						tok_push   = 1'b1;
						tok.kind   = fdfr_pkg::TOK_CLOSE;
						tok.status = fdfr_pkg::STAT_OVERLONG;
						esc_n      = 1'b0;
					end else begin
						raw_n = raw_q + fdfr_pkg::RAW_W'(1);
						if (esc_q) begin
							esc_n      = 1'b0;
							plain_take = 1'b1;
						end else if (rx_byte == fdfr_pkg::ESC_BYTE) begin
							esc_n = 1'b1;
						end else begin
							plain_take = 1'b1;
						end
						if (plain_take) begin
							pos_n = pos_inc;
							xor_n = xor_q ^ plain_val;
							// Only header bytes need to reach the back.
							if (pos_inc <= fdfr_pkg::POS_W'(fdfr_pkg::HDR_BYTES)) begin
								tok_push = 1'b1;
							end
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= fdfr_pkg::ST_HUNT;
			esc_q     <= 1'b0;
			raw_q     <= '0;
			pos_q     <= '0;
			xor_q     <= 8'h00;
			min_len_q <= fdfr_pkg::MIN_LEN_RESET;
		end else begin
			state_q <= state_n;
			esc_q   <= esc_n;
			raw_q   <= raw_n;
			pos_q   <= pos_n;
			xor_q   <= xor_n;
			if (min_frame_len_we) begin
				min_len_q <= min_frame_len_wdata;
			end
		end
	end

endmodule

>>> rtl/core/fdfr_queue.sv
// Short token queue between the front and the back of the receiver.
// Depends on fdfr_pkg for the token type and depth.
module fdfr_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  fdfr_pkg::tok_t push_tok,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output fdfr_pkg::tok_t head_tok
);

	fdfr_pkg::tok_t mem_q [fdfr_pkg::QUEUE_DEPTH];
	logic [fdfr_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [fdfr_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [fdfr_pkg::QCNT_W-1:0] count_q;
	logic                        do_push;
	logic                        do_pop;

	assign full     = (count_q == fdfr_pkg::QCNT_W'(fdfr_pkg::QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign head_tok = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + fdfr_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + fdfr_pkg::QPTR_W'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + fdfr_pkg::QCNT_W'(1);
				2'b01:   count_q <= count_q - fdfr_pkg::QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/core/fdfr_back.sv
// Back part of the receiver: header capture and the registered result stage.
// Consumes tokens from fdfr_queue; depends on fdfr_pkg.
module fdfr_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             q_empty,
	input  fdfr_pkg::tok_t                   q_tok,
	output logic                             q_pop,
	output logic                             res_valid,
	input  logic                             res_stall,
	output logic [1:0]                       frame_status,
	output logic [15:0]                      message_id,
	output logic [15:0]                      message_attr,
	output logic [fdfr_pkg::BODY_LEN_W-1:0]  body_length,
	output logic                             multi_packet,
	output logic [47:0]                      terminal_number,
	output logic [15:0]                      serial_number,
	output logic [15:0]                      packet_total,
	output logic [15:0]                      packet_index
);

	logic [7:0] hdr_q [fdfr_pkg::HDR_BYTES];
	logic       res_valid_q;
	logic       out_free;
	logic       take_close;
	logic       with_hdr;
	logic       multi;
	logic [15:0] attr;

	assign out_free   = !res_valid_q || !res_stall;
	assign q_pop      = !q_empty && (q_tok.kind == fdfr_pkg::TOK_PLAIN || out_free);
	assign take_close = q_pop && q_tok.kind == fdfr_pkg::TOK_CLOSE;
	assign with_hdr   = (q_tok.status == fdfr_pkg::STAT_GOOD) ||
	                    (q_tok.status == fdfr_pkg::STAT_CHECK);
	assign attr       = {hdr_q[2], hdr_q[3]};
	assign multi      = attr[fdfr_pkg::MULTI_BIT];
	assign res_valid  = res_valid_q;

	// The header is cleared after every close, so each frame starts from zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < fdfr_pkg::HDR_BYTES; i++) begin
				hdr_q[i] <= 8'h00;
			end
		end else if (q_pop) begin
			if (q_tok.kind == fdfr_pkg::TOK_CLOSE) begin
				for (int i = 0; i < fdfr_pkg::HDR_BYTES; i++) begin
					hdr_q[i] <= 8'h00;
				end
			end else begin
				hdr_q[q_tok.slot] <= q_tok.data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take_close) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_close) begin
			frame_status <= 2'(q_tok.status);
			if (with_hdr) begin
				message_id      <= {hdr_q[0], hdr_q[1]};
				message_attr    <= attr;
				body_length     <= attr[fdfr_pkg::BODY_LEN_W-1:0];
				multi_packet    <= multi;
				terminal_number <= {hdr_q[4], hdr_q[5], hdr_q[6],
				                    hdr_q[7], hdr_q[8], hdr_q[9]};
				serial_number   <= {hdr_q[10], hdr_q[11]};
				packet_total    <= multi ? {hdr_q[12], hdr_q[13]} : 16'h0000;
				packet_index    <= multi ? {hdr_q[14], hdr_q[15]} : 16'h0000;
			end else begin
				message_id      <= '0;
				message_attr    <= '0;
				body_length     <= '0;
				multi_packet    <= 1'b0;
				terminal_number <= '0;
				serial_number   <= '0;
				packet_total    <= '0;
				packet_index    <= '0;
			end
		end
	end

endmodule

>>> rtl/core/flag_delimited_frame_receiver.sv
// Flag-delimited frame receiver: one raw link byte per cycle, one result per frame.
// The byte rate holds unless rx_stall is raised because the token queue is full.
// A closing flag's token is written into the four-entry token queue; the back then
// moves it into the result register once that register is free.
// Reset is asynchronous and active low; the block then hunts for a head flag with
// min_frame_len at 15. Instantiates fdfr_front, fdfr_queue and fdfr_back.
module flag_delimited_frame_receiver (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             min_frame_len_we,
	input  logic [fdfr_pkg::MIN_LEN_W-1:0]  min_frame_len_wdata,
	input  logic                             rx_valid,
	output logic                             rx_stall,
	input  logic [7:0]                       rx_byte,
	output logic                             res_valid,
	input  logic                             res_stall,
	output logic [1:0]                       frame_status,
	output logic [15:0]                      message_id,
	output logic [15:0]                      message_attr,
	output logic [fdfr_pkg::BODY_LEN_W-1:0]  body_length,
	output logic                             multi_packet,
	output logic [47:0]                      terminal_number,
	output logic [15:0]                      serial_number,
	output logic [15:0]                      packet_total,
	output logic [15:0]                      packet_index
);

	logic           q_full;
	logic           q_empty;
	logic           q_push;
	logic           q_pop;
	fdfr_pkg::tok_t push_tok;
	fdfr_pkg::tok_t head_tok;

	fdfr_front u_front (
		.clk                 (clk),
		.arst_n              (arst_n),
		.min_frame_len_we    (min_frame_len_we),
		.min_frame_len_wdata (min_frame_len_wdata),
		.rx_valid            (rx_valid),
		.rx_byte             (rx_byte),
		.rx_stall            (rx_stall),
		.queue_full          (q_full),
		.tok_push            (q_push),
		.tok                 (push_tok)
	);

	fdfr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_tok (push_tok),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head_tok (head_tok)
	);

	fdfr_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_empty         (q_empty),
		.q_tok           (head_tok),
		.q_pop           (q_pop),
		.res_valid       (res_valid),
		.res_stall       (res_stall),
		.frame_status    (frame_status),
		.message_id      (message_id),
		.message_attr    (message_attr),
		.body_length     (body_length),
		.multi_packet    (multi_packet),
		.terminal_number (terminal_number),
		.serial_number   (serial_number),
		.packet_total    (packet_total),
		.packet_index    (packet_index)
	);

endmodule

>>> tb/frame_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the flag-delimited frame receiver: watches the byte, result and
// min_frame_len channels, predicts each frame result and compares it field by field.
// Depends on fdfr_pkg for the status codes, flag and escape bytes and field widths.
module frame_result_checker
	import fdfr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  min_frame_len_we,
	input  logic [MIN_LEN_W-1:0]  min_frame_len_wdata,
	input  logic                  rx_valid,
	input  logic                  rx_stall,
	input  logic [7:0]            rx_byte,
	input  logic                  res_valid,
	input  logic                  res_stall,
	input  logic [1:0]            frame_status,
	input  logic [15:0]           message_id,
	input  logic [15:0]           message_attr,
	input  logic [BODY_LEN_W-1:0] body_length,
	input  logic                  multi_packet,
	input  logic [47:0]           terminal_number,
	input  logic [15:0]           serial_number,
	input  logic [15:0]           packet_total,
	input  logic [15:0]           packet_index,
	output int                    fail_count,
	output int                    pending_results
);

	typedef struct {
		fr_status_t            status;
		logic [15:0]           id;
		logic [15:0]           attr;
		logic [BODY_LEN_W-1:0] blen;
		logic                  multi;
		logic [47:0]           term;
		logic [15:0]           serial;
		logic [15:0]           ptotal;
		logic [15:0]           pindex;
	} frame_result_t;

	frame_result_t expected_frames[$];

	logic [MIN_LEN_W-1:0] min_len;
	fr_state_t            rx_state;
	logic                 esc_pending;
	logic [RAW_W-1:0]     raw_count;
	logic [POS_W-1:0]     plain_pos;
	logic [7:0]           xor_sum;
	logic [63:0]          hdr_hi;
	logic [63:0]          hdr_lo;
	int                   errors = 0;

	task automatic open_frame();
		rx_state = ST_FRAME;
		esc_pending = 1'b0;
		raw_count = 1;
		plain_pos = 0;
		xor_sum = 8'h00;
		hdr_hi = 64'd0;
		hdr_lo = 64'd0;
	endtask

	task automatic take_plain(input logic [7:0] v);
		int p;
		plain_pos = plain_pos + 1'b1;
		p = plain_pos;
		xor_sum ^= v;
		// Header bytes 1-8 fill the upper word, 9-16 the lower, first byte on top.
		if (p >= 1 && p <= 8)
			hdr_hi |= 64'(v) << (8 * (8 - p));
		else if (p >= 9 && p <= HDR_BYTES)
			hdr_lo |= 64'(v) << (8 * (HDR_BYTES - p));
	endtask

	function automatic frame_result_t make_result(fr_status_t st, logic [63:0] h0,
			logic [63:0] h1);
		frame_result_t r;
		r.status = st;
		r.id = h0[63:48];
		r.attr = h0[47:32];
		r.blen = r.attr[BODY_LEN_W-1:0];
		r.multi = r.attr[MULTI_BIT];
		r.term = {h0[31:0], h1[63:48]};
		r.serial = h1[47:32];
		r.ptotal = r.multi ? h1[31:16] : 16'd0;
		r.pindex = r.multi ? h1[15:0] : 16'd0;
		return r;
	endfunction

	task automatic deframe_byte(input logic [7:0] b);
		fr_status_t st;
		if (rx_state == ST_HUNT) begin
			if (b == FLAG_BYTE)
				open_frame();
		end else if (b == FLAG_BYTE) begin
			if (raw_count < min_len)
				st = STAT_SHORT;
			else if (plain_pos == 0 || xor_sum != 8'h00)
				st = STAT_CHECK;
			else
				st = STAT_GOOD;
			if (st == STAT_SHORT)
				expected_frames.push_back(make_result(st, 64'd0, 64'd0));
			else
				expected_frames.push_back(make_result(st, hdr_hi, hdr_lo));
			// A rejected frame hands its closing flag on as the next head.
			if (st == STAT_GOOD) begin
				rx_state = ST_HUNT;
				esc_pending = 1'b0;
			end else begin
				open_frame();
			end
		end else if (raw_count >= RAW_FRAME_MAX - 1) begin
			expected_frames.push_back(make_result(STAT_OVERLONG, 64'd0, 64'd0));
			rx_state = ST_HUNT;
			esc_pending = 1'b0;
		end else begin
			raw_count = raw_count + 1'b1;
			if (esc_pending) begin
				esc_pending = 1'b0;
				if (b == ESC_CODE_ESC)
					take_plain(ESC_BYTE);
				else if (b == ESC_CODE_FLAG)
					take_plain(FLAG_BYTE);
				else
					take_plain(b);
			end else if (b == ESC_BYTE) begin
				esc_pending = 1'b1;
			end else begin
				take_plain(b);
			end
		end
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$error("%s expected 0x%0h, actual 0x%0h", name, want, got);
			errors++;
		end
	endtask

	task automatic check_result();
		frame_result_t r;
		if (expected_frames.size() == 0) begin
			$error("result transfer with no frame result outstanding");
			errors++;
		end else begin
			r = expected_frames.pop_front();
			check_field("frame_status", 64'(r.status), 64'(frame_status));
			check_field("message_id", 64'(r.id), 64'(message_id));
			check_field("message_attr", 64'(r.attr), 64'(message_attr));
			check_field("body_length", 64'(r.blen), 64'(body_length));
			check_field("multi_packet", 64'(r.multi), 64'(multi_packet));
			check_field("terminal_number", 64'(r.term), 64'(terminal_number));
			check_field("serial_number", 64'(r.serial), 64'(serial_number));
			check_field("packet_total", 64'(r.ptotal), 64'(packet_total));
			check_field("packet_index", 64'(r.pindex), 64'(packet_index));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len = MIN_LEN_RESET;
			rx_state = ST_HUNT;
			esc_pending = 1'b0;
			raw_count = 0;
			plain_pos = 0;
			xor_sum = 8'h00;
			hdr_hi = 64'd0;
			hdr_lo = 64'd0;
			expected_frames.delete();
			fail_count <= 0;
			pending_results <= 0;
		end else begin
			// Results are checked before this edge's byte is predicted, so a result
			// can never match a prediction made in the same cycle.
			if (res_valid && !res_stall)
				check_result();
			if (rx_valid && !rx_stall)
				deframe_byte(rx_byte);
			// A register write takes effect for bytes after this edge.
			if (min_frame_len_we)
				min_len = min_frame_len_wdata;
			if (res_valid === 1'bx) begin
				$error("res_valid expected 0x0 or 0x1, actual 0x%0h", res_valid);
				errors++;
			end
			fail_count <= errors;
			pending_results <= expected_frames.size();
		end
	end

endmodule

>>> tb/tb_flag_delimited_frame_receiver.sv
`timescale 1ns / 1ps
// Top of the flag-delimited frame receiver testbench: clock, reset, byte stimulus,
// result-side stalls and the verdict. Uses frame_result_checker and fdfr_pkg.
module tb_flag_delimited_frame_receiver;
	import fdfr_pkg::*;

	localparam int LIMIT_CYCLES = 300000;
	localparam int LONG_HOLD    = 300;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  min_frame_len_we = 1'b0;
	logic [MIN_LEN_W-1:0]  min_frame_len_wdata = '0;
	logic                  rx_valid = 1'b0;
	logic                  rx_stall;
	logic [7:0]            rx_byte = 8'h00;
	logic                  res_valid;
	logic                  res_stall = 1'b0;
	logic [1:0]            frame_status;
	logic [15:0]           message_id;
	logic [15:0]           message_attr;
	logic [BODY_LEN_W-1:0] body_length;
	logic                  multi_packet;
	logic [47:0]           terminal_number;
	logic [15:0]           serial_number;
	logic [15:0]           packet_total;
	logic [15:0]           packet_index;

	int fail_count;
	int pending_results;
	int items_sent = 0;
	int cycles = 0;
	int stall_left = 0;
	bit quiet = 1'b0;
	bit long_hold_req = 1'b0;
	bit long_hold_taken = 1'b0;

	always #5 clk = ~clk;

	flag_delimited_frame_receiver uut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.min_frame_len_we    (min_frame_len_we),
		.min_frame_len_wdata (min_frame_len_wdata),
		.rx_valid            (rx_valid),
		.rx_stall            (rx_stall),
		.rx_byte             (rx_byte),
		.res_valid           (res_valid),
		.res_stall           (res_stall),
		.frame_status        (frame_status),
		.message_id          (message_id),
		.message_attr        (message_attr),
		.body_length         (body_length),
		.multi_packet        (multi_packet),
		.terminal_number     (terminal_number),
		.serial_number       (serial_number),
		.packet_total        (packet_total),
		.packet_index        (packet_index)
	);

	frame_result_checker result_check (
		.clk                 (clk),
		.arst_n              (arst_n),
		.min_frame_len_we    (min_frame_len_we),
		.min_frame_len_wdata (min_frame_len_wdata),
		.rx_valid            (rx_valid),
		.rx_stall            (rx_stall),
		.rx_byte             (rx_byte),
		.res_valid           (res_valid),
		.res_stall           (res_stall),
		.frame_status        (frame_status),
		.message_id          (message_id),
		.message_attr        (message_attr),
		.body_length         (body_length),
		.multi_packet        (multi_packet),
		.terminal_number     (terminal_number),
		.serial_number       (serial_number),
		.packet_total        (packet_total),
		.packet_index        (packet_index),
		.fail_count          (fail_count),
		.pending_results     (pending_results)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("flag_delimited_frame_receiver verification failed");
			$finish;
		end
	end

	// Result-side stalls: random bursts, one long hold on request, none when quiet.
	always @(posedge clk) begin
		if (long_hold_req && !long_hold_taken) begin
			long_hold_taken <= 1'b1;
			res_stall <= 1'b1;
			stall_left = LONG_HOLD;
		end else if (stall_left > 0) begin
			stall_left--;
		end else if (quiet) begin
			res_stall <= 1'b0;
		end else begin
			res_stall <= ($urandom_range(0, 2) == 0);
			stall_left = $urandom_range(0, 9);
		end
	end

	task automatic send_byte(input logic [7:0] b);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			rx_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (rx_stall)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic wait_idle();
		rx_valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_min_len(input logic [MIN_LEN_W-1:0] v);
		min_frame_len_we <= 1'b1;
		min_frame_len_wdata <= v;
		@(posedge clk);
		min_frame_len_we <= 1'b0;
	endtask

	function automatic logic [7:0] literal_byte();
		logic [7:0] v;
		do
			v = 8'($urandom_range(0, 255));
		while (v == FLAG_BYTE || v == ESC_BYTE);
		return v;
	endfunction

	// Sends one plain byte with link escaping; odd_esc also escapes ordinary bytes,
	// which the receiver passes through unchanged.
	task automatic send_plain(input logic [7:0] v, input bit odd_esc);
		if (v == FLAG_BYTE) begin
			send_byte(ESC_BYTE);
			send_byte(ESC_CODE_FLAG);
		end else if (v == ESC_BYTE) begin
			send_byte(ESC_BYTE);
			send_byte(odd_esc ? ESC_BYTE : ESC_CODE_ESC);
		end else if (odd_esc && v != ESC_CODE_ESC && v != ESC_CODE_FLAG) begin
			send_byte(ESC_BYTE);
			send_byte(v);
		end else begin
			send_byte(v);
		end
	endtask

	task automatic send_frame(input int body_max);
		logic [7:0]  p[$];
		logic [7:0]  x;
		logic [15:0] attr;
		int          flaw;
		int          keep;
		flaw = $urandom_range(0, 9);
		attr = 16'($urandom);
		x = 8'h00;
		p = {};
		repeat (2) p.push_back(8'($urandom));
		p.push_back(attr[15:8]);
		p.push_back(attr[7:0]);
		repeat (8) p.push_back(8'($urandom));
		if (attr[MULTI_BIT])
			repeat (4) p.push_back(8'($urandom));
		repeat ($urandom_range(0, body_max)) p.push_back(8'($urandom));
		// Truncated frames leave part of the header unreceived.
		if (flaw == 7) begin
			keep = $urandom_range(0, HDR_BYTES - 1);
			while (p.size() > keep)
				void'(p.pop_back());
		end
		foreach (p[i])
			x ^= p[i];
		if (flaw == 6)
			x ^= 8'h01 << $urandom_range(0, 7);
		p.push_back(x);
		send_byte(FLAG_BYTE);
		foreach (p[i])
			send_plain(p[i], flaw == 9 && $urandom_range(0, 3) == 0);
		if (flaw == 8)
			send_byte(ESC_BYTE);
		send_byte(FLAG_BYTE);
	endtask

	task automatic run_traffic(input int n);
		int stop;
		stop = items_sent + n;
		while (items_sent < stop) begin
			case ($urandom_range(0, 9))
				0: repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
				1: send_byte(FLAG_BYTE);
				default: send_frame(($urandom_range(0, 7) == 0) ? 80 : 16);
			endcase
		end
	endtask

	// Largest frames: one closing exactly at the last legal raw index, one overlong.
	task automatic send_long_frames();
		logic [7:0] x;
		logic [7:0] b;
		x = 8'h00;
		send_byte(FLAG_BYTE);
		repeat (RAW_FRAME_MAX - 4) begin
			b = literal_byte();
			x ^= b;
			send_byte(b);
		end
		do
			b = literal_byte();
		while ((x ^ b) == FLAG_BYTE || (x ^ b) == ESC_BYTE);
		send_byte(b);
		send_byte(x ^ b);
		send_byte(FLAG_BYTE);
		send_byte(FLAG_BYTE);
		repeat (RAW_FRAME_MAX - 1) send_byte(literal_byte());
		repeat (3) send_byte(literal_byte());
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: hunting noise, a frame that is too short, a dangling escape,
		// good frames with every escape form including unknown ones.
		write_min_len(9'd2);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(ESC_BYTE);
		send_byte(FLAG_BYTE);
		send_byte(FLAG_BYTE);
		send_byte(ESC_BYTE);
		send_byte(FLAG_BYTE);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(FLAG_BYTE);
		send_byte(FLAG_BYTE);
		send_byte(ESC_BYTE);
		send_byte(ESC_CODE_ESC);
		send_byte(ESC_BYTE);
		send_byte(ESC_CODE_FLAG);
		send_byte(ESC_BYTE);
		send_byte(8'h33);
		send_byte(ESC_BYTE);
		send_byte(ESC_BYTE);
		send_byte(8'h41);
		send_byte(8'h0C);
		send_byte(FLAG_BYTE);
		wait_idle();

		write_min_len(MIN_LEN_RESET);
		run_traffic(80);

		// Hold the result side for a long stretch while flags keep producing results.
		long_hold_req <= 1'b1;
		repeat (40) send_byte(FLAG_BYTE);
		run_traffic(20);
		wait_idle();

		write_min_len(9'd0);
		run_traffic(50);
		wait_idle();

		write_min_len(9'd1);
		run_traffic(30);
		wait_idle();

		write_min_len(9'($urandom_range(2, 40)));
		run_traffic(50);
		wait_idle();

		write_min_len(9'd511);
		run_traffic(20);
		send_long_frames();
		wait_idle();

		quiet <= 1'b1;
		write_min_len(MIN_LEN_RESET);
		run_traffic(60);
		wait_idle();

		if (fail_count == 0)
			$display("flag_delimited_frame_receiver verification clean");
		else
			$display("flag_delimited_frame_receiver verification failed");
		$finish;
	end

endmodule
